// ===== design/khash_pkg.sv =====
// Package for the keyed 64-bit hash core: constants, state types and the
// round, absorb and fold functions used by the core and its finalizer.
// No dependencies.
`timescale 1ns / 1ps

package khash_pkg;

  localparam int WordW          = 64;
  localparam int NbW            = 4;
  localparam int LenW           = 8;
  localparam int WordBytes      = WordW / 8;
  localparam int CompressRounds = 2;
  localparam int FinalRounds    = 4;
  localparam int MaxRounds      = 8;

  localparam logic [WordW-1:0] Init0     = 64'h736f6d6570736575;
  localparam logic [WordW-1:0] Init1     = 64'h646f72616e646f6d;
  localparam logic [WordW-1:0] Init2     = 64'h6c7967656e657261;
  localparam logic [WordW-1:0] Init3     = 64'h7465646279746573;
  localparam logic [WordW-1:0] FinalMark = 64'h00000000000000ff;

  typedef enum logic [0:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
  } sip_state_t;

  // handoff of a finished message from the core to the finalizer
  typedef struct packed {
    sip_state_t      st;
    logic            need_tail;
    logic [LenW-1:0] len;
  } fin_req_t;

  function automatic logic [WordW-1:0] rotl64(logic [WordW-1:0] x, int r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1;  t.v1 = rotl64(t.v1, 13);  t.v1 = t.v1 ^ t.v0;
    t.v0 = rotl64(t.v0, 32);
    t.v2 = t.v2 + t.v3;  t.v3 = rotl64(t.v3, 16);  t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3;  t.v3 = rotl64(t.v3, 21);  t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1;  t.v1 = rotl64(t.v1, 17);  t.v1 = t.v1 ^ t.v2;
    t.v2 = rotl64(t.v2, 32);
    return t;
  endfunction

  // n is always an elaboration-time constant
  function automatic sip_state_t sip_rounds(sip_state_t s, int n);
    sip_state_t t;
    t = s;
    for (int i = 0; i < MaxRounds; i++) begin
      if (i < n) t = sip_round(t);
    end
    return t;
  endfunction

  function automatic sip_state_t sip_absorb(sip_state_t s, logic [WordW-1:0] m);
    sip_state_t t;
    t = s;
    t.v3 = t.v3 ^ m;
    t = sip_rounds(t, CompressRounds);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

  function automatic logic [WordW-1:0] sip_fold(sip_state_t s);
    return s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
  endfunction

endpackage

// ===== design/khash_in_if.sv =====
// Input channel of the keyed hash core: one message word per beat.
// Depends on khash_pkg.
`timescale 1ns / 1ps

interface khash_in_if;
  logic                         valid;
  logic                         ready;
  logic [khash_pkg::WordW-1:0]  data_word;
  logic [khash_pkg::NbW-1:0]    valid_bytes;
  logic                         is_last;

  modport source (output valid, output data_word, output valid_bytes, output is_last,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bytes, input is_last,
                  output ready);
endinterface

// ===== design/khash_out_if.sv =====
// Output channel of the keyed hash core: one hash per beat.
// Depends on khash_pkg.
`timescale 1ns / 1ps

interface khash_out_if;
  logic                         valid;
  logic                         ready;
  logic [khash_pkg::WordW-1:0]  hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== design/khash_fin.sv =====
// Finalization pipeline: tail block, final mark, final rounds two per stage,
// fold into the output register. Elastic stages with per-stage valid.
// Depends on khash_pkg and khash_out_if.
`timescale 1ns / 1ps

module khash_fin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  khash_pkg::fin_req_t req_i,
  khash_out_if.source         out_bus
);
  import khash_pkg::*;

  localparam int NumChunks = (FinalRounds + 1) / 2;
  localparam int NumStg    = NumChunks + 1;

  function automatic int chunk_rounds(int j);
    return (FinalRounds - 2 * j > 2) ? 2 : FinalRounds - 2 * j;
  endfunction

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] rdy;
  logic [NumStg-1:0] up_vld;
  sip_state_t        st_q [NumStg];
  sip_state_t        st_d [NumStg];
  logic              need_tail_q;
  logic [LenW-1:0]   len_q;
  logic              out_vld_q;
  logic [WordW-1:0]  hash_q;
  logic [WordW-1:0]  hash_d;
  logic              out_rdy;

  assign out_rdy = !out_vld_q || out_bus.ready;

  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    if (k == NumStg - 1) begin : g_tail_rdy
      assign rdy[k] = !vld_q[k] || out_rdy;
    end else begin : g_mid_rdy
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end

    if (k == 0) begin : g_in
      assign up_vld[k] = req_valid_i;
      assign st_d[k]   = req_i.st;
    end else if (k == 1) begin : g_tailblk
      sip_state_t t;
      assign up_vld[k] = vld_q[k-1];
      // full last word leaves an empty tail block holding only the length
      always_comb begin
        t = need_tail_q ? sip_absorb(st_q[k-1], {len_q, {(WordW-LenW){1'b0}}})
                        : st_q[k-1];
        t.v2 = t.v2 ^ FinalMark;
      end
      assign st_d[k] = t;
    end else begin : g_rounds
      assign up_vld[k] = vld_q[k-1];
      assign st_d[k]   = sip_rounds(st_q[k-1], chunk_rounds(k - 2));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= up_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && up_vld[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && req_valid_i) begin
      need_tail_q <= req_i.need_tail;
      len_q       <= req_i.len;
    end
  end

  assign hash_d = sip_fold(sip_rounds(st_q[NumStg-1], chunk_rounds(NumChunks - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= vld_q[NumStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && vld_q[NumStg-1]) begin
      hash_q <= hash_d;
    end
  end

  assign req_ready_o        = rdy[0];
  assign out_bus.valid      = out_vld_q;
  assign out_bus.hash_value = hash_q;

endmodule

// ===== design/keyed_hash_64_core.sv =====
// Channel   | dir | beat contents                          | completes when
// in_bus    | in  | data_word, valid_bytes, is_last        | valid & ready
// out_bus   | out | hash_value (one per message)           | valid & ready
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i        | cfg_we_i high
//
// One word is taken per cycle while in_bus.ready is high; the running state absorbs it with two rounds.
// A last word passes an input stage, one stage for the tail block and final mark, and two
// rounds per following stage before the hash reaches the output register.
// Reset clears the key, the message-open flag and all stage valids.
// in_bus.ready drops only when every finalizer stage is full and out is stalled.
// Keyed hash core and the state loop; depends on khash_pkg, khash_in_if,
// khash_out_if and khash_fin.
`timescale 1ns / 1ps

module keyed_hash_64_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  khash_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [khash_pkg::WordW-1:0]  cfg_data_i,
  khash_in_if.sink                     in_bus,
  khash_out_if.source                  out_bus
);
  import khash_pkg::*;

  logic [WordW-1:0] key_lo_q;
  logic [WordW-1:0] key_hi_q;
  sip_state_t       v_q;
  logic [LenW-1:0]  len_q;
  logic             open_q;

  sip_state_t       init_st;
  sip_state_t       cur_st;
  sip_state_t       abs_st;
  logic [LenW-1:0]  len_cur;
  logic [LenW-1:0]  len_next;
  logic [NbW-1:0]   nb;
  logic             full_blk;
  logic [WordW-1:0] tail_word;
  logic [WordW-1:0] blk;
  logic             in_beat;
  logic             fin_valid;
  logic             fin_ready;
  fin_req_t         fin_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
        CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign init_st = '{v0: Init0 ^ key_lo_q, v1: Init1 ^ key_hi_q,
                     v2: Init2 ^ key_lo_q, v3: Init3 ^ key_hi_q};
  assign cur_st  = open_q ? v_q : init_st;
  assign len_cur = open_q ? len_q : '0;

  // oversized byte counts saturate to a full word
  assign nb       = (in_bus.valid_bytes > NbW'(WordBytes)) ? NbW'(WordBytes)
                                                           : in_bus.valid_bytes;
  assign full_blk = !in_bus.is_last || (nb == NbW'(WordBytes));
  assign len_next = len_cur + (full_blk ? LenW'(WordBytes) : LenW'(nb));

  always_comb begin
    tail_word = '0;
    for (int b = 0; b < WordBytes; b++) begin
      if (b < int'(nb)) tail_word[8*b +: 8] = in_bus.data_word[8*b +: 8];
    end
    tail_word[WordW-1 -: LenW] = tail_word[WordW-1 -: LenW] | len_next;
  end

  assign blk    = full_blk ? in_bus.data_word : tail_word;
  assign abs_st = sip_absorb(cur_st, blk);

  assign in_beat = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (in_beat) begin
      open_q <= !in_bus.is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && !in_bus.is_last) begin
      v_q   <= abs_st;
      len_q <= len_next;
    end
  end

  assign fin_valid         = in_beat && in_bus.is_last;
  assign fin_req.st        = abs_st;
  assign fin_req.need_tail = (nb == NbW'(WordBytes));
  assign fin_req.len       = len_next;

  khash_fin u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (fin_valid),
    .req_ready_o (fin_ready),
    .req_i       (fin_req),
    .out_bus     (out_bus)
  );

  assign in_bus.ready = fin_ready;

  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled while finalizer output is not stalled");

  a_open_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !in_bus.is_last) |=> open_q)
    else $error("message not open after a non-last word");

  a_closed_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_bus.is_last) |=> !open_q)
    else $error("message still open after the last word");

endmodule

// ===== bench/tb_keyed_hash_64_core.sv =====
// Self-checking bench for keyed_hash_64_core: directed table, then random messages,
// every hash beat compared against an in-bench SipHash-2-4 predictor or a known table hash.
// Depends on khash_pkg, khash_in_if, khash_out_if and keyed_hash_64_core.
`timescale 1ns / 1ps

module tb_keyed_hash_64_core;
  import khash_pkg::*;

  localparam int          RAND_WORDS   = 400;
  localparam int          PHASES       = 5;
  localparam int          DRAIN_CYCLES = 10;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam logic [63:0] ONES         = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_KEYS
  } row_kind_e;

  // aux holds the known hash on a word row, key_high on a key row (data is key_low)
  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] data;
    logic [3:0]  nb;
    logic        last;
    logic        known;
    logic [63:0] aux;
  } stim_row_t;

  localparam int NUM_ROWS = 21;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    // zero key straight out of reset
    '{ROW_WORD, ONES, 4'd0, 1'b1, 1'b0, 64'h0},  // empty message, all bytes masked off
    '{ROW_WORD, 64'h0, 4'd8, 1'b1, 1'b0, 64'h0},  // full last word, then empty tail
    '{ROW_KEYS, 64'h0706050403020100, 4'd0, 1'b0, 1'b0, 64'h0f0e0d0c0b0a0908},
    '{ROW_WORD, 64'h0, 4'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
    '{ROW_WORD, 64'h0706050403020100, 4'd8, 1'b1, 1'b1, 64'h93f5f5799a932462},
    // byte counts above eight saturate, then short last words
    '{ROW_WORD, ONES, 4'd15, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, 64'h8000_0000_0000_0001, 4'd9, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, 64'hdead_beef_0123_4567, 4'd1, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, ONES, 4'd3, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, ONES, 4'd7, 1'b1, 1'b0, 64'h0},
    // multi-word: byte count ignored on non-last words
    '{ROW_WORD, ONES, 4'd0, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, 64'h0, 4'd15, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, 64'h5555_aaaa_5555_aaaa, 4'd4, 1'b1, 1'b0, 64'h0},
    // key swap mid-message: open message keeps the old key
    '{ROW_WORD, 64'h0123_4567_89ab_cdef, 4'd5, 1'b0, 1'b0, 64'h0},
    '{ROW_KEYS, ONES, 4'd0, 1'b0, 1'b0, ONES},
    '{ROW_WORD, 64'hfedc_ba98_7654_3210, 4'd6, 1'b1, 1'b0, 64'h0},
    '{ROW_WORD, 64'hffff_0000_ffff_0000, 4'd2, 1'b1, 1'b0, 64'h0},
    '{ROW_KEYS, 64'h0, 4'd0, 1'b0, 1'b0, ONES},
    '{ROW_WORD, ONES, 4'd8, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, 64'h0, 4'd14, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, 64'h0102_0304_0506_0708, 4'd5, 1'b1, 1'b0, 64'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [63:0] cfg_data;

  khash_in_if  in_ch ();
  khash_out_if out_ch ();

  keyed_hash_64_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_bus     (in_ch),
    .out_bus    (out_ch)
  );

  // predictor state
  logic [63:0] key_lo_m;
  logic [63:0] key_hi_m;
  logic [63:0] st [4];
  logic [7:0]  len_cnt;
  logic        msg_open;

  logic [63:0] hash_expected [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned words_sent;
  bit          calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_keyed_hash_64_core: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rol64(logic [63:0] x, int r);
    logic [127:0] dbl;
    dbl = {x, x};
    return dbl[(127 - r) -: 64];
  endfunction

  function automatic void mix_round();
    st[0] = st[0] + st[1];  st[1] = rol64(st[1], 13) ^ st[0];
    st[0] = rol64(st[0], 32);
    st[2] = st[2] + st[3];  st[3] = rol64(st[3], 16) ^ st[2];
    st[0] = st[0] + st[3];  st[3] = rol64(st[3], 21) ^ st[0];
    st[2] = st[2] + st[1];  st[1] = rol64(st[1], 17) ^ st[2];
    st[2] = rol64(st[2], 32);
  endfunction

  function automatic void absorb_block(logic [63:0] m);
    st[3] = st[3] ^ m;
    for (int i = 0; i < CompressRounds; i++) mix_round();
    st[0] = st[0] ^ m;
  endfunction

  // returns 1 when the word closes a message; h is then its hash
  function automatic bit predict_word(input logic [63:0] w, input logic [3:0] nb,
                                      input logic last, output logic [63:0] h);
    logic [63:0] tail;
    int unsigned n;
    h = '0;
    if (!msg_open) begin
      st[0]    = Init0 ^ key_lo_m;
      st[1]    = Init1 ^ key_hi_m;
      st[2]    = Init2 ^ key_lo_m;
      st[3]    = Init3 ^ key_hi_m;
      len_cnt  = '0;
      msg_open = 1'b1;
    end
    if (!last) begin
      absorb_block(w);
      len_cnt = len_cnt + 8'd8;
      return 1'b0;
    end
    n = (nb > 4'd8) ? 8 : nb;
    if (n == 8) begin
      absorb_block(w);
      len_cnt = len_cnt + 8'd8;
      tail    = '0;
    end else begin
      len_cnt = len_cnt + 8'(n);
      tail    = w & ~(ONES << (8 * n));
    end
    tail[63:56] = len_cnt;
    absorb_block(tail);
    st[2] = st[2] ^ FinalMark;
    for (int i = 0; i < FinalRounds; i++) mix_round();
    h        = st[0] ^ st[1] ^ st[2] ^ st[3];
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH @%0t: %s got %016h want %016h", $time, what, got, want);
    errors++;
  endtask

  // hash receiver: check every beat, stall at random outside the calm phase
  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hash_expected.size() == 0) begin
        report_mismatch("unexpected hash beat", out_ch.hash_value, 64'h0);
      end else begin
        want = hash_expected.pop_front();
        if (out_ch.hash_value !== want)
          report_mismatch("hash_value", out_ch.hash_value, want);
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 38);
  end

  task automatic push_word(input logic [63:0] w, input logic [3:0] nb, input logic last,
                           input logic known, input logic [63:0] known_hash);
    logic [63:0] h;
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_word   <= w;
    in_ch.valid_bytes <= nb;
    in_ch.is_last     <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (predict_word(w, nb, last, h))
      hash_expected.push_back(known ? known_hash : h);
  endtask

  // sender holds off until every hash is out and the finalizer has emptied
  task automatic drain_hashes();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_keys(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_KEY_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= CFG_KEY_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    key_lo_m = lo;
    key_hi_m = hi;
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(3))
      0:       return 64'h0;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_message();
    int unsigned body;
    int unsigned r;
    logic [3:0]  nb;
    r = $urandom_range(99);
    if (r < 6) body = $urandom_range(40, 30);  // 30 to 40 body words, which can wrap the byte count
    else body = $urandom_range(5);
    for (int i = 0; i < body; i++)
      push_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0, 1'b0, 64'h0);
    if ($urandom_range(99) < 15) nb = 4'($urandom_range(15, 9));
    else nb = 4'($urandom_range(8));
    push_word({$urandom, $urandom}, nb, 1'b1, 1'b0, 64'h0);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_KEY_LOW;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = '0;
    in_ch.valid_bytes = '0;
    in_ch.is_last     = 1'b0;
    out_ch.ready      = 1'b0;
    key_lo_m          = '0;
    key_hi_m          = '0;
    st                = '{default: '0};
    len_cnt           = '0;
    msg_open          = 1'b0;
    errors            = 0;
    cycles            = 0;
    words_sent        = 0;
    calm              = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_KEYS) begin
        drain_hashes();
        write_keys(DIR_ROWS[i].data, DIR_ROWS[i].aux);
      end else begin
        push_word(DIR_ROWS[i].data, DIR_ROWS[i].nb, DIR_ROWS[i].last,
                  DIR_ROWS[i].known, DIR_ROWS[i].aux);
      end
    end

    words_sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_hashes();
      write_keys(pick_key(), pick_key());
      calm = (p == 2);  // one phase with no stalls on either side
      while (words_sent < (p + 1) * RAND_WORDS / PHASES) send_message();
    end
    calm = 1'b0;

    drain_hashes();
    if (errors == 0) $display("tb_keyed_hash_64_core: done, clean");
    else $display("tb_keyed_hash_64_core: done, errors");
    $finish;
  end

endmodule
